// File: design/stretched_span_shader_assert.svh
// Assertion macros used by the span shader top-level design file.
`ifndef STRETCHED_SPAN_SHADER_ASSERT_SVH
`define STRETCHED_SPAN_SHADER_ASSERT_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define SSPAN_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("span shader same-cycle check failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define SSPAN_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("span shader next-cycle check failed");

`endif

// File: design/sspan_pkg.sv
// Shared constants, codes and the pipeline item type of the span shader.
package sspan_pkg;

   localparam int POS_W        = 26;
   localparam int ENTRY_IDX_W  = 10;
   localparam int BYTE_W       = 8;
   localparam int ACTION_W     = 3;
   localparam int MODE_W       = 2;
   localparam int CSR_IDX_W    = 2;
   localparam int CSR_DATA_W   = 8;
   localparam int REMAP_DEPTH  = 256;
   localparam int BLEND_ADDR_W = 2 * BYTE_W;
   localparam int BLEND_DEPTH  = 1 << BLEND_ADDR_W;

   localparam int FRAC_BITS_DEFAULT = 16;
   localparam int SRC_LEN_DEFAULT   = 1024;

   // Beat actions.
   localparam logic [ACTION_W-1:0] ACT_LOAD_SRC   = 3'd0;
   localparam logic [ACTION_W-1:0] ACT_LOAD_REMAP = 3'd1;
   localparam logic [ACTION_W-1:0] ACT_LOAD_BLEND = 3'd2;
   localparam logic [ACTION_W-1:0] ACT_START      = 3'd3;
   localparam logic [ACTION_W-1:0] ACT_PIXEL      = 3'd4;

   // Draw modes.
   localparam logic [MODE_W-1:0] MODE_COPY  = 2'd0;
   localparam logic [MODE_W-1:0] MODE_REMAP = 2'd1;
   localparam logic [MODE_W-1:0] MODE_BLEND = 2'd2;

   // Control register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_DRAW_MODE  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_ENABLE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_VALUE  = 2'd2;

   typedef struct packed {
      logic [ACTION_W-1:0]    action;
      logic [ENTRY_IDX_W-1:0] entry_index;
      logic [BYTE_W-1:0]      blend_dest;
      logic [BYTE_W-1:0]      entry_value;
      logic [BYTE_W-1:0]      dest_pixel;
   } item_type;

endpackage

// File: design/stretched_span_shader.sv
// A pixel beat passes the input register, NSTEP index reduction stages, the source store,
// the table stage and the result register. NSTEP is the number of index reduction stages
// (26 - FRAC_BITS - clog2(SRC_LEN) + 1, at least 0); with the default parameters it is 1.
// One beat per cycle while req_stall is low; the position accumulator is a single 26-bit add.
// Reset (synchronous, active high) clears position, step, control registers and all
// pipeline valid bits; the table memories are not cleared and hold nothing defined.
`include "stretched_span_shader_assert.svh"

module stretched_span_shader
   import sspan_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEFAULT,
   parameter int SRC_LEN   = SRC_LEN_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   // Input beats.
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [ACTION_W-1:0]    req_action,
   input  logic [ENTRY_IDX_W-1:0] req_entry_index,
   input  logic [BYTE_W-1:0]      req_blend_dest_index,
   input  logic [BYTE_W-1:0]      req_entry_value,
   input  logic [POS_W-1:0]       req_start_position,
   input  logic signed [POS_W-1:0] req_position_step,
   input  logic [BYTE_W-1:0]      req_dest_pixel,
   // Result beats.
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [BYTE_W-1:0]      rsp_pixel_out,
   output logic                   rsp_write_enable,
   // Control register writes.
   input  logic                   csr_write,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   // The integer part of the position is IW bits wide. It is reduced modulo SRC_LEN by
   // a chain of compare-and-subtract stages, one shifted copy of SRC_LEN per stage.
   localparam int IW     = POS_W - FRAC_BITS;
   localparam int SIDX_W = $clog2(SRC_LEN);
   localparam int NSTEP  = (IW >= SIDX_W) ? (IW - SIDX_W + 1) : 0;
   localparam int RW     = (IW > SIDX_W) ? IW : SIDX_W;

   // Control registers.
   logic [MODE_W-1:0] draw_mode_ff;
   logic              key_enable_ff;
   logic [BYTE_W-1:0] key_value_ff;

   // Span state.
   logic [POS_W-1:0] position_ff;
   logic [POS_W-1:0] position_in;
   logic [POS_W-1:0] position_sum;
   logic [POS_W-1:0] step_ff;
   logic [POS_W-1:0] step_in;

   // Input register stage.
   logic          s0_valid_ff;
   item_type      s0_item_ff;
   logic [RW-1:0] s0_residue_ff;
   logic          s0_ready;
   logic          req_fire;
   item_type      req_item;

   // Reduction chain; entry 0 is the input register, entry NSTEP feeds the source store.
   logic          chain_valid   [NSTEP + 1];
   logic          chain_ready   [NSTEP + 1];
   item_type      chain_item    [NSTEP + 1];
   logic [RW-1:0] chain_residue [NSTEP + 1];

   // Source and table stages.
   logic              src_valid;
   logic              src_ready;
   item_type          src_item;
   logic [BYTE_W-1:0] src_sample;
   logic              lut_valid;
   logic              lut_ready;
   item_type          lut_item;
   logic [BYTE_W-1:0] lut_sample;
   logic [BYTE_W-1:0] lut_remap;
   logic [BYTE_W-1:0] lut_blend;

   // Result register.
   logic              rsp_valid_ff;
   logic [BYTE_W-1:0] rsp_pixel_ff;
   logic              rsp_write_ff;
   logic              keyed;
   logic [BYTE_W-1:0] pixel_in;

   // ---------------------------------------------------------------------------------
   // Control register writes. Writes to the unused index are dropped.
   // ---------------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         draw_mode_ff  <= MODE_COPY;
         key_enable_ff <= 1'b0;
         key_value_ff  <= '0;
      end else if (csr_write) begin
         case (csr_index)
            CSR_DRAW_MODE:  draw_mode_ff  <= csr_wdata[MODE_W-1:0];
            CSR_KEY_ENABLE: key_enable_ff <= csr_wdata[0];
            CSR_KEY_VALUE:  key_value_ff  <= csr_wdata[BYTE_W-1:0];
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------------------------
   // Input handshake and position accumulator. A start beat loads position and step;
   // each pixel beat takes the current position into the pipeline and advances it by
   // the step, wrapping modulo 2^26. A negative step wraps downwards on its own since
   // the add is two's complement.
   // ---------------------------------------------------------------------------------
   assign s0_ready  = !s0_valid_ff || chain_ready[0];
   assign req_stall = !s0_ready;
   assign req_fire  = req_valid && s0_ready;

   assign position_sum = position_ff + step_ff;

   always_comb begin
      position_in = position_ff;
      step_in     = step_ff;
      if (req_fire && (req_action == ACT_START)) begin
         position_in = req_start_position;
         step_in     = unsigned'(req_position_step);
      end else if (req_fire && (req_action == ACT_PIXEL)) begin
         position_in = position_sum;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         position_ff <= '0;
         step_ff     <= '0;
      end else begin
         position_ff <= position_in;
         step_ff     <= step_in;
      end
   end

   always_comb begin
      req_item.action      = req_action;
      req_item.entry_index = req_entry_index;
      req_item.blend_dest  = req_blend_dest_index;
      req_item.entry_value = req_entry_value;
      req_item.dest_pixel  = req_dest_pixel;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else if (s0_ready) begin
         s0_valid_ff <= req_valid;
      end
   end

   // Every beat carries the integer part of the current position, so the reduction
   // stages never see an unreduced value at the source store.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         s0_item_ff    <= req_item;
         s0_residue_ff <= RW'(position_ff[POS_W-1:FRAC_BITS]);
      end
   end

   assign chain_valid[0]   = s0_valid_ff;
   assign chain_item[0]    = s0_item_ff;
   assign chain_residue[0] = s0_residue_ff;

   // ---------------------------------------------------------------------------------
   // Modulo reduction: stage j subtracts SRC_LEN shifted left by NSTEP-1-j when it fits.
   // ---------------------------------------------------------------------------------
   for (genvar j = 0; j < NSTEP; j++) begin : g_mod
      sspan_mod_step #(
         .SRC_LEN(SRC_LEN),
         .RW     (RW),
         .SHIFT  (NSTEP - 1 - j)
      ) u_mod_step (
         .clock      (clock),
         .reset      (reset),
         .in_valid   (chain_valid[j]),
         .in_ready   (chain_ready[j]),
         .in_item    (chain_item[j]),
         .in_residue (chain_residue[j]),
         .out_valid  (chain_valid[j + 1]),
         .out_ready  (chain_ready[j + 1]),
         .out_item   (chain_item[j + 1]),
         .out_residue(chain_residue[j + 1])
      );
   end

   // ---------------------------------------------------------------------------------
   // Source store and table stages. Loads and reads of one store happen in the same
   // stage, in beat order, so a load always lands before any later pixel reads it.
   // ---------------------------------------------------------------------------------
   sspan_src_line #(
      .SRC_LEN(SRC_LEN),
      .RW     (RW)
   ) u_src_line (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (chain_valid[NSTEP]),
      .in_ready  (chain_ready[NSTEP]),
      .in_item   (chain_item[NSTEP]),
      .in_residue(chain_residue[NSTEP]),
      .out_valid (src_valid),
      .out_ready (src_ready),
      .out_item  (src_item),
      .out_sample(src_sample)
   );

   sspan_lut u_lut (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (src_valid),
      .in_ready  (src_ready),
      .in_item   (src_item),
      .in_sample (src_sample),
      .out_valid (lut_valid),
      .out_ready (lut_ready),
      .out_item  (lut_item),
      .out_sample(lut_sample),
      .out_remap (lut_remap),
      .out_blend (lut_blend)
   );

   // ---------------------------------------------------------------------------------
   // Shading and result register. A keyed-out pixel returns the destination unchanged
   // with the write enable low. Draw mode 3 behaves as a plain copy. Only pixel beats
   // produce results; other beats are dropped here after their loads are done.
   // ---------------------------------------------------------------------------------
   always_comb begin
      keyed = key_enable_ff && (lut_sample == key_value_ff);
      case (draw_mode_ff)
         MODE_REMAP: pixel_in = lut_remap;
         MODE_BLEND: pixel_in = lut_blend;
         default:    pixel_in = lut_sample;
      endcase
      if (keyed) begin
         pixel_in = lut_item.dest_pixel;
      end
   end

   assign lut_ready = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (lut_ready) begin
         rsp_valid_ff <= lut_valid && (lut_item.action == ACT_PIXEL);
      end
   end

   always_ff @(posedge clock) begin
      if (lut_valid && lut_ready) begin
         rsp_pixel_ff <= pixel_in;
         rsp_write_ff <= !keyed;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_pixel_out    = rsp_pixel_ff;
   assign rsp_write_enable = rsp_write_ff;

   // ---------------------------------------------------------------------------------
   // Checks.
   // ---------------------------------------------------------------------------------
   `SSPAN_ASSERT_NEXT(a_pixel_advances, clock, reset, req_fire && (req_action == ACT_PIXEL), position_ff == $past(position_sum))
   `SSPAN_ASSERT_NEXT(a_start_loads, clock, reset, req_fire && (req_action == ACT_START), position_ff == $past(req_start_position))
   `SSPAN_ASSERT_NOW(a_keyed_needs_key, clock, reset, rsp_valid && !rsp_write_enable, key_enable_ff)
   `SSPAN_ASSERT_NOW(a_result_from_lut, clock, reset, $rose(rsp_valid), $past(lut_valid))

endmodule

// File: design/sspan_mod_step.sv
// One compare-and-subtract stage of the source index reduction pipeline.
module sspan_mod_step
   import sspan_pkg::*;
#(
   parameter int SRC_LEN = SRC_LEN_DEFAULT,
   parameter int RW      = 10,
   parameter int SHIFT   = 0
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          in_valid,
   output logic          in_ready,
   input  item_type      in_item,
   input  logic [RW-1:0] in_residue,
   output logic          out_valid,
   input  logic          out_ready,
   output item_type      out_item,
   output logic [RW-1:0] out_residue
);

   localparam logic [RW:0] DIVISOR = (RW + 1)'(SRC_LEN) << SHIFT;

   logic          valid_ff;
   item_type      item_ff;
   logic [RW-1:0] residue_ff;
   logic [RW:0]   ext_residue;
   logic [RW:0]   reduced;
   logic [RW-1:0] residue_in;

   // Subtract the shifted line length when it fits; the result stays below it.
   always_comb begin
      ext_residue = {1'b0, in_residue};
      reduced     = (ext_residue >= DIVISOR) ? (ext_residue - DIVISOR) : ext_residue;
      residue_in  = reduced[RW-1:0];
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         item_ff    <= in_item;
         residue_ff <= residue_in;
      end
   end

   assign out_valid   = valid_ff;
   assign out_item    = item_ff;
   assign out_residue = residue_ff;

endmodule

// File: design/sspan_src_line.sv
// Source line store stage: performs source loads and reads the sample for pixels.
module sspan_src_line
   import sspan_pkg::*;
#(
   parameter int SRC_LEN = SRC_LEN_DEFAULT,
   parameter int RW      = 10
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  item_type          in_item,
   input  logic [RW-1:0]     in_residue,
   output logic              out_valid,
   input  logic              out_ready,
   output item_type          out_item,
   output logic [BYTE_W-1:0] out_sample
);

   localparam int SIDX_W = $clog2(SRC_LEN);
   localparam int XW     = (ENTRY_IDX_W > SIDX_W + 1) ? ENTRY_IDX_W : SIDX_W + 1;

   logic [BYTE_W-1:0] line_mem [SRC_LEN];

   logic              valid_ff;
   item_type          item_ff;
   logic [BYTE_W-1:0] sample_ff;
   logic              load;
   logic [XW-1:0]     wide_index;
   logic              write_hit;
   logic [SIDX_W-1:0] write_addr;
   logic [SIDX_W-1:0] read_addr;

   assign in_ready   = !valid_ff || out_ready;
   assign load       = in_valid && in_ready;
   assign wide_index = XW'(in_item.entry_index);
   assign write_addr = wide_index[SIDX_W-1:0];
   assign read_addr  = in_residue[SIDX_W-1:0];
   assign write_hit  = (in_item.action == ACT_LOAD_SRC) && (wide_index < XW'(SRC_LEN));

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (load && write_hit) begin
         line_mem[write_addr] <= in_item.entry_value;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff   <= in_item;
         sample_ff <= line_mem[read_addr];
      end
   end

   assign out_valid  = valid_ff;
   assign out_item   = item_ff;
   assign out_sample = sample_ff;

endmodule

// File: design/sspan_lut.sv
// Remap and blend table stage: performs table loads and looks up both tables.
module sspan_lut
   import sspan_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  item_type          in_item,
   input  logic [BYTE_W-1:0] in_sample,
   output logic              out_valid,
   input  logic              out_ready,
   output item_type          out_item,
   output logic [BYTE_W-1:0] out_sample,
   output logic [BYTE_W-1:0] out_remap,
   output logic [BYTE_W-1:0] out_blend
);

   logic [BYTE_W-1:0] remap_mem [REMAP_DEPTH];
   logic [BYTE_W-1:0] blend_mem [BLEND_DEPTH];

   logic                    valid_ff;
   item_type                item_ff;
   logic [BYTE_W-1:0]       sample_ff;
   logic [BYTE_W-1:0]       remap_ff;
   logic [BYTE_W-1:0]       blend_ff;
   logic                    load;
   logic                    index_in_range;
   logic [BLEND_ADDR_W-1:0] blend_write_addr;
   logic [BLEND_ADDR_W-1:0] blend_read_addr;

   assign in_ready         = !valid_ff || out_ready;
   assign load             = in_valid && in_ready;
   assign index_in_range   = (in_item.entry_index[ENTRY_IDX_W-1:BYTE_W] == '0);
   assign blend_write_addr = {in_item.entry_index[BYTE_W-1:0], in_item.blend_dest};
   assign blend_read_addr  = {in_sample, in_item.dest_pixel};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (load && index_in_range && (in_item.action == ACT_LOAD_REMAP)) begin
         remap_mem[in_item.entry_index[BYTE_W-1:0]] <= in_item.entry_value;
      end
   end

   always_ff @(posedge clock) begin
      if (load && index_in_range && (in_item.action == ACT_LOAD_BLEND)) begin
         blend_mem[blend_write_addr] <= in_item.entry_value;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff   <= in_item;
         sample_ff <= in_sample;
         remap_ff  <= remap_mem[in_sample];
         blend_ff  <= blend_mem[blend_read_addr];
      end
   end

   assign out_valid  = valid_ff;
   assign out_item   = item_ff;
   assign out_sample = sample_ff;
   assign out_remap  = remap_ff;
   assign out_blend  = blend_ff;

endmodule

// File: test/stretched_span_shader_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the span shader: table loads, spans and pixels against a predictor.
import sspan_pkg::*;

localparam int SPAN_FRAC = FRAC_BITS_DEFAULT;
localparam int SPAN_LEN  = SRC_LEN_DEFAULT;

typedef struct packed {
   logic [ACTION_W-1:0]    action;
   logic [ENTRY_IDX_W-1:0] entry_index;
   logic [BYTE_W-1:0]      blend_dest;
   logic [BYTE_W-1:0]      entry_value;
   logic [POS_W-1:0]       start_position;
   logic [POS_W-1:0]       position_step;
   logic [BYTE_W-1:0]      dest_pixel;
} span_beat_type;

typedef struct packed {
   logic [BYTE_W-1:0] pixel;
   logic              written;
} shaded_pixel_type;

class span_scoreboard;
   localparam int MAX_REPORTS = 10;

   logic [BYTE_W-1:0] source_line [SPAN_LEN];
   bit                source_known [SPAN_LEN];
   logic [BYTE_W-1:0] remap_lut [REMAP_DEPTH];
   bit                remap_known [REMAP_DEPTH];
   logic [BYTE_W-1:0] blend_lut [BLEND_DEPTH];
   bit                blend_known [BLEND_DEPTH];
   logic [POS_W-1:0]  position = '0;
   logic [POS_W-1:0]  stride = '0;
   logic [MODE_W-1:0] draw_mode = MODE_COPY;
   logic              key_enable = 1'b0;
   logic [BYTE_W-1:0] key_value = '0;
   shaded_pixel_type  shaded_pixels [$];
   int                errors = 0;

   // Source slot that the next pixel beat will read.
   function int source_slot();
      return int'(position >> SPAN_FRAC) % SPAN_LEN;
   endfunction

   function void write_register(logic [CSR_IDX_W-1:0] index, logic [CSR_DATA_W-1:0] data);
      case (index)
         CSR_DRAW_MODE:  draw_mode = data[MODE_W-1:0];
         CSR_KEY_ENABLE: key_enable = data[0];
         CSR_KEY_VALUE:  key_value = data[BYTE_W-1:0];
         default: ;
      endcase
   endfunction

   function shaded_pixel_type shade_pixel(logic [BYTE_W-1:0] dest);
      shaded_pixel_type  result;
      logic [BYTE_W-1:0] texel;
      texel = source_line[source_slot()];
      position = position + stride;
      result.written = 1'b1;
      if (key_enable && texel == key_value) begin
         result.pixel = dest;
         result.written = 1'b0;
      end else if (draw_mode == MODE_REMAP) begin
         result.pixel = remap_lut[texel];
      end else if (draw_mode == MODE_BLEND) begin
         result.pixel = blend_lut[{texel, dest}];
      end else begin
         result.pixel = texel;
      end
      return result;
   endfunction

   function void note_beat(span_beat_type beat);
      case (beat.action)
         ACT_LOAD_SRC: begin
            if (beat.entry_index < SPAN_LEN) begin
               source_line[beat.entry_index] = beat.entry_value;
               source_known[beat.entry_index] = 1'b1;
            end
         end
         ACT_LOAD_REMAP: begin
            if (beat.entry_index < REMAP_DEPTH) begin
               remap_lut[beat.entry_index[BYTE_W-1:0]] = beat.entry_value;
               remap_known[beat.entry_index[BYTE_W-1:0]] = 1'b1;
            end
         end
         ACT_LOAD_BLEND: begin
            if (beat.entry_index < REMAP_DEPTH) begin
               blend_lut[{beat.entry_index[BYTE_W-1:0], beat.blend_dest}] = beat.entry_value;
               blend_known[{beat.entry_index[BYTE_W-1:0], beat.blend_dest}] = 1'b1;
            end
         end
         ACT_START: begin
            position = beat.start_position;
            stride = beat.position_step;
         end
         ACT_PIXEL: shaded_pixels.push_back(shade_pixel(beat.dest_pixel));
         default: ;
      endcase
   endfunction

   function void check_pixel(logic [BYTE_W-1:0] pixel, logic written);
      shaded_pixel_type want;
      if (shaded_pixels.size() == 0) begin
         errors++;
         if (errors <= MAX_REPORTS)
            $display("result beat with nothing outstanding: pixel_out %h write_enable %b",
                     pixel, written);
         return;
      end
      want = shaded_pixels.pop_front();
      if (pixel !== want.pixel || written !== want.written) begin
         errors++;
         if (errors <= MAX_REPORTS)
            $display("pixel mismatch: expected pixel_out %h write_enable %b, got %h %b",
                     want.pixel, want.written, pixel, written);
      end
   endfunction
endclass

module stretched_span_shader_tb;
   // Codes that the package leaves unnamed but the block must tolerate.
   localparam logic [MODE_W-1:0]    MODE_SPARE   = 2'd3;
   localparam logic [ACTION_W-1:0]  ACT_SPARE_LO = 3'd5;
   localparam logic [ACTION_W-1:0]  ACT_SPARE_HI = 3'd7;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE    = 2'd3;

   localparam logic [POS_W-1:0] STEP_MAX = {1'b0, {(POS_W-1){1'b1}}};
   localparam logic [POS_W-1:0] STEP_MIN = {1'b1, {(POS_W-1){1'b0}}};
   localparam logic [POS_W-1:0] ONE_TEXEL = POS_W'(1 << SPAN_FRAC);

   localparam int IDLE_PERCENT  = 8;
   // This margin lets loads still in flight drain out of the pipeline.
   localparam int SETTLE_CYCLES = 12;
   localparam int HOLD_CYCLES   = 150;
   localparam int PHASE_PIXELS  = 20;

   logic                    clock;
   logic                    reset;
   logic                    req_valid;
   logic                    req_stall;
   logic [ACTION_W-1:0]     req_action;
   logic [ENTRY_IDX_W-1:0]  req_entry_index;
   logic [BYTE_W-1:0]       req_blend_dest_index;
   logic [BYTE_W-1:0]       req_entry_value;
   logic [POS_W-1:0]        req_start_position;
   logic signed [POS_W-1:0] req_position_step;
   logic [BYTE_W-1:0]       req_dest_pixel;
   logic                    rsp_valid;
   logic                    rsp_stall;
   logic [BYTE_W-1:0]       rsp_pixel_out;
   logic                    rsp_write_enable;
   logic                    csr_write;
   logic [CSR_IDX_W-1:0]    csr_index;
   logic [CSR_DATA_W-1:0]   csr_wdata;

   span_scoreboard sb;
   // While steady is set neither side idles at random.
   bit             steady;
   // Set by the sender to ask the result side for one long hold-off.
   bit             hold_request;
   int             pixels_sent;

   stretched_span_shader dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_action           (req_action),
      .req_entry_index      (req_entry_index),
      .req_blend_dest_index (req_blend_dest_index),
      .req_entry_value      (req_entry_value),
      .req_start_position   (req_start_position),
      .req_position_step    (req_position_step),
      .req_dest_pixel       (req_dest_pixel),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_pixel_out        (rsp_pixel_out),
      .rsp_write_enable     (rsp_write_enable),
      .csr_write            (csr_write),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Hard stop, far beyond the slowest legal run.
   initial begin
      #2_000_000;
      $display("stretched_span_shader verification failed");
      $finish;
   end

   // Result side: checks every accepted result beat and drives the stall. A hold-off
   // request from the sender is counted down here, cycle by cycle.
   initial begin
      int hold_left;
      hold_left = 0;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall)
            sb.check_pixel(rsp_pixel_out, rsp_write_enable);
         if (hold_request) begin
            hold_left = HOLD_CYCLES;
            hold_request = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= !steady && ($urandom_range(99) < IDLE_PERCENT);
         end
      end
   end

   // Every field gets random content, so fields that an action ignores still toggle.
   function automatic span_beat_type random_beat(logic [ACTION_W-1:0] action);
      span_beat_type beat;
      beat.action = action;
      beat.entry_index = ENTRY_IDX_W'($urandom);
      beat.blend_dest = BYTE_W'($urandom);
      beat.entry_value = BYTE_W'($urandom);
      beat.start_position = POS_W'($urandom);
      beat.position_step = POS_W'($urandom);
      beat.dest_pixel = BYTE_W'($urandom);
      return beat;
   endfunction

   function automatic span_beat_type load_beat(logic [ACTION_W-1:0] action, int index,
                                               logic [BYTE_W-1:0] value);
      span_beat_type beat;
      beat = random_beat(action);
      beat.entry_index = ENTRY_IDX_W'(index);
      beat.entry_value = value;
      return beat;
   endfunction

   // Source bytes lean toward the key so that keyed-out pixels show up often.
   function automatic logic [BYTE_W-1:0] source_value();
      if (sb.key_enable && $urandom_range(3) == 0)
         return sb.key_value;
      return BYTE_W'($urandom);
   endfunction

   // Half the destinations come from a few fixed colors (0, 85, 170, 255) so that
   // blend entries get reused, the rest are random.
   function automatic logic [BYTE_W-1:0] pick_dest();
      if ($urandom_range(1))
         return BYTE_W'($urandom);
      return BYTE_W'($urandom_range(3) * 85);
   endfunction

   // Mostly small steps of either sign, sometimes the extremes or any value at all.
   function automatic logic [POS_W-1:0] pick_step();
      logic [POS_W-1:0] magnitude;
      magnitude = POS_W'($urandom_range(0, 3 << SPAN_FRAC));
      case ($urandom_range(9))
         0: return POS_W'($urandom);
         1: return $urandom_range(1) ? STEP_MAX : STEP_MIN;
         default: return $urandom_range(1) ? -magnitude : magnitude;
      endcase
   endfunction

   // A key taken from a loaded source byte where there is one, so that it really hits.
   function automatic logic [BYTE_W-1:0] pick_key();
      int slot;
      slot = $urandom_range(SPAN_LEN - 1);
      return sb.source_known[slot] ? sb.source_line[slot] : BYTE_W'($urandom);
   endfunction

   // Offers one beat and holds it until the block takes it. The payload only changes
   // after acceptance, and valid stays high into the next beat unless an idle gap falls.
   task automatic send_beat(span_beat_type beat);
      req_valid            <= 1'b1;
      req_action           <= beat.action;
      req_entry_index      <= beat.entry_index;
      req_blend_dest_index <= beat.blend_dest;
      req_entry_value      <= beat.entry_value;
      req_start_position   <= beat.start_position;
      req_position_step    <= beat.position_step;
      req_dest_pixel       <= beat.dest_pixel;
      do @(posedge clock); while (req_stall);
      sb.note_beat(beat);
      if (!steady && $urandom_range(99) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
   endtask

   task automatic start_span(logic [POS_W-1:0] start, logic [POS_W-1:0] step);
      span_beat_type beat;
      beat = random_beat(ACT_START);
      beat.start_position = start;
      beat.position_step = step;
      send_beat(beat);
   endtask

   // Sends one pixel. Any table entry that the pixel will read and that was never
   // written is loaded first, since the tables come up undefined.
   task automatic send_pixel(logic [BYTE_W-1:0] dest);
      span_beat_type     beat;
      int                slot;
      logic [BYTE_W-1:0] texel;
      slot = sb.source_slot();
      if (!sb.source_known[slot])
         send_beat(load_beat(ACT_LOAD_SRC, slot, source_value()));
      texel = sb.source_line[slot];
      if (!(sb.key_enable && texel == sb.key_value)) begin
         if (sb.draw_mode == MODE_REMAP && !sb.remap_known[texel])
            send_beat(load_beat(ACT_LOAD_REMAP, int'(texel), BYTE_W'($urandom)));
         if (sb.draw_mode == MODE_BLEND && !sb.blend_known[{texel, dest}]) begin
            beat = load_beat(ACT_LOAD_BLEND, int'(texel), BYTE_W'($urandom));
            beat.blend_dest = dest;
            send_beat(beat);
         end
      end
      beat = random_beat(ACT_PIXEL);
      beat.dest_pixel = dest;
      send_beat(beat);
      pixels_sent++;
   endtask

   // Stops offering beats until every pixel has come back, then lets any trailing
   // load drain out of the pipeline.
   task automatic wait_for_results();
      req_valid <= 1'b0;
      while (sb.shaded_pixels.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(logic [CSR_IDX_W-1:0] index, logic [CSR_DATA_W-1:0] data);
      csr_write <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(posedge clock);
      sb.write_register(index, data);
      csr_write <= 1'b0;
      @(posedge clock);
   endtask

   // Unused upper data bits carry junk on the narrow registers; only the low bits count.
   task automatic configure(logic [MODE_W-1:0] mode, logic enable, logic [BYTE_W-1:0] key);
      logic [CSR_DATA_W-1:0] data;
      wait_for_results();
      data = CSR_DATA_W'($urandom);
      data[MODE_W-1:0] = mode;
      write_register(CSR_DRAW_MODE, data);
      data = CSR_DATA_W'($urandom);
      data[0] = enable;
      write_register(CSR_KEY_ENABLE, data);
      write_register(CSR_KEY_VALUE, key);
   endtask

   // Random traffic: mostly spans of pixels, plus table rewrites and a little noise
   // (reserved actions and out-of-range loads that the block must drop).
   task automatic run_phase(int pixel_quota);
      int            target;
      int            pick;
      span_beat_type beat;
      target = pixels_sent + pixel_quota;
      while (pixels_sent < target) begin
         pick = $urandom_range(99);
         if (pick < 8) begin
            case ($urandom_range(2))
               0: beat = random_beat(ACTION_W'($urandom_range(ACT_SPARE_LO, ACT_SPARE_HI)));
               1: beat = load_beat(ACT_LOAD_REMAP, $urandom_range(REMAP_DEPTH, SPAN_LEN - 1),
                                   BYTE_W'($urandom));
               default: beat = load_beat(ACT_LOAD_BLEND,
                                         $urandom_range(REMAP_DEPTH, SPAN_LEN - 1),
                                         BYTE_W'($urandom));
            endcase
            send_beat(beat);
         end else if (pick < 20) begin
            case ($urandom_range(2))
               0: beat = load_beat(ACT_LOAD_SRC, $urandom_range(SPAN_LEN - 1), source_value());
               1: beat = load_beat(ACT_LOAD_REMAP, $urandom_range(REMAP_DEPTH - 1),
                                   BYTE_W'($urandom));
               default: beat = load_beat(ACT_LOAD_BLEND, $urandom_range(REMAP_DEPTH - 1),
                                         BYTE_W'($urandom));
            endcase
            send_beat(beat);
         end else begin
            start_span(POS_W'($urandom), pick_step());
            repeat ($urandom_range(1, 16)) send_pixel(pick_dest());
         end
      end
   endtask

   initial begin
      sb = new();
      steady = 1'b0;
      hold_request = 1'b0;
      pixels_sent = 0;
      reset                <= 1'b1;
      req_valid            <= 1'b0;
      req_action           <= ACT_LOAD_SRC;
      req_entry_index      <= '0;
      req_blend_dest_index <= '0;
      req_entry_value      <= '0;
      req_start_position   <= '0;
      req_position_step    <= '0;
      req_dest_pixel       <= '0;
      csr_write            <= 1'b0;
      csr_index            <= CSR_DRAW_MODE;
      csr_wdata            <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part, in the reset configuration (plain copy, keying off).
      // Extreme source bytes at both ends of the line.
      send_beat(load_beat(ACT_LOAD_SRC, SPAN_LEN - 1, 8'hFF));
      send_beat(load_beat(ACT_LOAD_SRC, 0, 8'h00));
      // Out-of-range remap and blend loads, and the reserved actions, are dropped.
      send_beat(load_beat(ACT_LOAD_REMAP, SPAN_LEN - 1, BYTE_W'($urandom)));
      send_beat(load_beat(ACT_LOAD_BLEND, REMAP_DEPTH, BYTE_W'($urandom)));
      for (int code = ACT_SPARE_LO; code <= ACT_SPARE_HI; code++)
         send_beat(random_beat(ACTION_W'(code)));
      // One texel per pixel from the start of the line.
      start_span('0, ONE_TEXEL);
      send_pixel(8'h00);
      send_pixel(8'hFF);
      // The position register wraps from all ones back to zero.
      start_span({POS_W{1'b1}}, POS_W'(1));
      send_pixel(pick_dest());
      send_pixel(pick_dest());
      // Walking backwards off the start of the line lands on its last slot.
      start_span('0, -ONE_TEXEL);
      send_pixel(pick_dest());
      send_pixel(pick_dest());
      // The largest steps of either sign.
      start_span(POS_W'($urandom), STEP_MAX);
      send_pixel(pick_dest());
      send_pixel(pick_dest());
      start_span(POS_W'($urandom), STEP_MIN);
      send_pixel(pick_dest());
      send_pixel(pick_dest());

      // Random phases over a spread of register settings, extremes first.
      configure(MODE_COPY, 1'b1, 8'h00);
      run_phase(PHASE_PIXELS);
      configure(MODE_REMAP, 1'b0, 8'hFF);
      run_phase(PHASE_PIXELS);
      configure(MODE_BLEND, 1'b1, 8'hFF);
      write_register(CSR_SPARE, CSR_DATA_W'($urandom));
      run_phase(PHASE_PIXELS);
      // The spare draw mode behaves as a plain copy.
      configure(MODE_SPARE, 1'b1, pick_key());
      run_phase(PHASE_PIXELS);

      // Back-pressure phase with no random idling: the result side holds off long
      // enough for the pipeline to fill and stall the input, then the sender pauses
      // until everything has come back before carrying on.
      configure(MODE_BLEND, 1'b1, pick_key());
      steady = 1'b1;
      run_phase(10);
      hold_request = 1'b1;
      run_phase(30);
      wait_for_results();
      run_phase(10);
      steady = 1'b0;

      configure(MODE_REMAP, 1'b1, pick_key());
      run_phase(PHASE_PIXELS);
      repeat (3) begin
         configure(MODE_W'($urandom_range(MODE_SPARE)), 1'($urandom_range(1)), pick_key());
         run_phase(PHASE_PIXELS);
      end

      wait_for_results();
      if (sb.errors == 0 && sb.shaded_pixels.size() == 0)
         $display("stretched_span_shader verification clean");
      else
         $display("stretched_span_shader verification failed");
      $finish;
   end
endmodule
